>>> rtl/core/quadratic_root_solver_unit_macros.svh
// Assertion macros for the quadratic root solver unit
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH

// implication checked outside reset
`define QRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also active during reset
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/qrs_pkg.sv
// Package: widths, stage types and helpers for the quadratic root solver
package qrs_pkg;
    localparam int FRAC_BITS = 16;
    localparam int CW   = 16;
    localparam int DW   = 34;
    localparam int OUT_W = 34;
    localparam int SW   = 17 + FRAC_BITS;
    localparam int RADW = 2 * SW;
    localparam int RMW  = SW + 2;
    localparam int NW   = SW + 1;
    localparam int DMW  = CW + 1;
    localparam int EW   = ((NW > OUT_W) ? NW : OUT_W) + 1;
    localparam int IN_W  = 48;
    localparam int TD_W  = 176;

    localparam int TD_LEGAL = 0;
    localparam int TD_REAL  = 1;
    localparam int TD_DBL   = 2;
    localparam int TD_DISC  = 3;
    localparam int TD_R1R   = TD_DISC + DW;
    localparam int TD_R1I   = TD_R1R + OUT_W;
    localparam int TD_R2R   = TD_R1I + OUT_W;
    localparam int TD_R2I   = TD_R2R + OUT_W;

    typedef struct packed {
        logic                  valid;
        logic signed [CW-1:0]  a;
        logic signed [CW-1:0]  b;
        logic signed [DW-1:0]  disc;
        logic [RADW-1:0]       rad;
        logic [RMW-1:0]        rem;
        logic [SW-1:0]         root;
    } sq_t;

    typedef struct packed {
        logic                  valid;
        logic                  legal;
        logic                  hasr;
        logic                  dbl;
        logic signed [DW-1:0]  disc;
        logic [2:0]            neg;
        logic [DMW-1:0]        dm;
        logic [2:0][NW-1:0]    num;
        logic [2:0][DMW-1:0]   rem;
    } dv_t;

    function automatic logic signed [OUT_W-1:0] sat_q(input logic neg,
                                                      input logic [NW-1:0] mag);
        logic [EW-1:0] m;
        logic [EW-1:0] maxe;
        logic signed [OUT_W-1:0] r;
        m    = EW'(mag);
        maxe = (EW'(1) << (OUT_W - 1)) - EW'(1);
        if (neg) begin
            if (m > maxe + EW'(1)) r = {1'b1, {(OUT_W-1){1'b0}}};
            else r = OUT_W'(EW'(0) - m);
        end else begin
            if (m > maxe) r = {1'b0, {(OUT_W-1){1'b1}}};
            else r = OUT_W'(m);
        end
        return r;
    endfunction
endpackage

>>> rtl/core/quadratic_root_solver_unit.sv
// Quadratic root solver: one coefficient set per cycle while the row advances. Two
// products, the discriminant, a row of square root cells (one root bit each,
// 17 + FRAC_BITS cells), numerator setup, a row of divider cells (one quotient bit
// each for three lanes, 18 + FRAC_BITS cells) and an output register. The whole row
// advances whenever the output register is empty or taken.
module quadratic_root_solver_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [qrs_pkg::IN_W-1:0] s_tdata,   // coef_a, coef_b, coef_c
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [qrs_pkg::TD_W-1:0] m_tdata    // is_legal, has_real_roots, double_root,
                                                // disc_value, root1_real, root1_imag,
                                                // root2_real, root2_imag, zero pad
);
    import qrs_pkg::*;

    logic adv;
    logic out_valid_reg;
    logic [TD_W-1:0] out_data_reg, out_data_next;

    logic sa_valid_reg;
    logic signed [CW-1:0] sa_a_reg, sa_b_reg;
    logic signed [2*CW-1:0] sa_bb_reg, sa_ac_reg;

    sq_t sq [0:SW];
    dv_t dv [0:NW];
    sq_t sq0_reg, sq0_next;
    dv_t dv0_reg, dv0_next;

    logic signed [DW-1:0] disc_w;
    logic [DW-1:0] mag_w;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
        end else if (adv) begin
            sa_valid_reg <= s_tvalid;
            sa_a_reg  <= signed'(s_tdata[CW-1:0]);
            sa_b_reg  <= signed'(s_tdata[2*CW-1:CW]);
            sa_bb_reg <= signed'(s_tdata[2*CW-1:CW]) * signed'(s_tdata[2*CW-1:CW]);
            sa_ac_reg <= signed'(s_tdata[CW-1:0]) * signed'(s_tdata[3*CW-1:2*CW]);
        end
    end

    always_comb begin
        disc_w = DW'(sa_bb_reg) - (DW'(sa_ac_reg) <<< 2);
        mag_w  = disc_w[DW-1] ? DW'(-disc_w) : DW'(disc_w);
        sq0_next.valid = sa_valid_reg;
        sq0_next.a     = sa_a_reg;
        sq0_next.b     = sa_b_reg;
        sq0_next.disc  = disc_w;
        sq0_next.rad   = RADW'({mag_w, {(2*FRAC_BITS){1'b0}}});
        sq0_next.rem   = '0;
        sq0_next.root  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq0_reg.valid <= 1'b0;
        end else if (adv) begin
            sq0_reg <= sq0_next;
        end
    end

    assign sq[0] = sq0_reg;

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .cell_in(sq[g]), .cell_out(sq[g+1])
        );
    end

    logic signed [NW:0] nb_w, s_w;
    logic signed [2:0][NW:0] n_w;
    logic signed [DMW-1:0] den_w;
    logic legal_w, hasr_w;

    always_comb begin
        legal_w = (sq[SW].a != '0);
        hasr_w  = legal_w && !sq[SW].disc[DW-1];
        nb_w    = (NW+1)'(-(DMW'(sq[SW].b))) <<< FRAC_BITS;
        s_w     = signed'((NW+1)'(sq[SW].root));
        n_w[0]  = hasr_w ? nb_w + s_w : nb_w;
        n_w[1]  = hasr_w ? nb_w - s_w : nb_w;
        n_w[2]  = s_w;
        den_w   = DMW'(sq[SW].a) <<< 1;
        dv0_next.valid = sq[SW].valid;
        dv0_next.legal = legal_w;
        dv0_next.hasr  = hasr_w;
        dv0_next.dbl   = hasr_w && (sq[SW].disc == '0);
        dv0_next.disc  = sq[SW].disc;
        dv0_next.dm    = den_w[DMW-1] ? DMW'(-den_w) : DMW'(den_w);
        dv0_next.rem   = '0;
        for (int i = 0; i < 3; i++) begin
            dv0_next.neg[i] = n_w[i][NW] ^ sq[SW].a[CW-1];
            dv0_next.num[i] = n_w[i][NW] ? NW'(-n_w[i]) : NW'(n_w[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv0_reg.valid <= 1'b0;
        end else if (adv) begin
            dv0_reg <= dv0_next;
        end
    end

    assign dv[0] = dv0_reg;

    for (genvar g = 0; g < NW; g++) begin : g_div
        qrs_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .cell_in(dv[g]), .cell_out(dv[g+1])
        );
    end

    logic signed [OUT_W-1:0] r1r, r1i, r2r, r2i;

    always_comb begin
        r1r = '0;
        r1i = '0;
        r2r = '0;
        r2i = '0;
        if (dv[NW].legal) begin
            r1r = sat_q(dv[NW].neg[0], dv[NW].num[0]);
            r2r = sat_q(dv[NW].neg[1], dv[NW].num[1]);
            if (!dv[NW].hasr) begin
                r1i = sat_q(dv[NW].neg[2], dv[NW].num[2]);
                r2i = (r1i == {1'b1, {(OUT_W-1){1'b0}}}) ?
                      {1'b0, {(OUT_W-1){1'b1}}} : -r1i;
            end
        end
        out_data_next = '0;
        out_data_next[TD_LEGAL] = dv[NW].legal;
        out_data_next[TD_REAL]  = dv[NW].hasr;
        out_data_next[TD_DBL]   = dv[NW].dbl;
        out_data_next[TD_DISC +: DW]  = dv[NW].disc;
        out_data_next[TD_R1R +: OUT_W] = r1r;
        out_data_next[TD_R1I +: OUT_W] = r1i;
        out_data_next[TD_R2R +: OUT_W] = r2r;
        out_data_next[TD_R2I +: OUT_W] = r2i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv[NW].valid;
        end
        if (adv) out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

>>> rtl/core/qrs_sqrt_cell.sv
// Square root cell: one root bit per stage, restoring, no multiplier
module qrs_sqrt_cell (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  qrs_pkg::sq_t cell_in,
    output qrs_pkg::sq_t cell_out
);
    import qrs_pkg::*;

    sq_t cell_reg, cell_next;
    logic [RMW-1:0] t, trial;

    always_comb begin
        cell_next = cell_in;
        t     = {cell_in.rem[RMW-3:0], cell_in.rad[RADW-1 -: 2]};
        trial = {cell_in.root, 2'b01};
        cell_next.rad = {cell_in.rad[RADW-3:0], 2'b00};
        if (t >= trial) begin
            cell_next.rem  = t - trial;
            cell_next.root = {cell_in.root[SW-2:0], 1'b1};
        end else begin
            cell_next.rem  = t;
            cell_next.root = {cell_in.root[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (adv) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;
endmodule

>>> rtl/core/qrs_div_cell.sv
// Divider cell: one quotient bit per stage for each of three lanes
module qrs_div_cell (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  qrs_pkg::dv_t cell_in,
    output qrs_pkg::dv_t cell_out
);
    import qrs_pkg::*;

    dv_t cell_reg, cell_next;
    logic [2:0][DMW-1:0] t;

    always_comb begin
        cell_next = cell_in;
        for (int i = 0; i < 3; i++) begin
            t[i] = {cell_in.rem[i][DMW-2:0], cell_in.num[i][NW-1]};
            if (t[i] >= cell_in.dm) begin
                cell_next.rem[i] = t[i] - cell_in.dm;
                cell_next.num[i] = {cell_in.num[i][NW-2:0], 1'b1};
            end else begin
                cell_next.rem[i] = t[i];
                cell_next.num[i] = {cell_in.num[i][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (adv) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;
endmodule

>>> rtl/core/qrs_checker.sv
// Port checker for the quadratic root solver, bound to the top level
`include "quadratic_root_solver_unit_macros.svh"

module qrs_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [qrs_pkg::TD_W-1:0] m_tdata
);
    import qrs_pkg::*;

    `QRS_ASSERT_NEXT(a_rst_empty, !aresetn, !m_tvalid, "word valid after reset")
    `QRS_ASSERT_IMPL(a_hold, m_tvalid && !m_tready && !s_tready ##1 1'b1, m_tvalid, "word dropped")
    `QRS_ASSERT_IMPL(a_dbl_real, m_tvalid && m_tdata[TD_DBL], m_tdata[TD_REAL], "double root not real")
    `QRS_ASSERT_IMPL(a_real_legal, m_tvalid && m_tdata[TD_REAL], m_tdata[TD_LEGAL], "real but illegal")
    `QRS_ASSERT_IMPL(a_illegal_zero, m_tvalid && !m_tdata[TD_LEGAL], m_tdata[TD_W-1:TD_R1R] == '0, "roots not zero")
endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (.*);

>>> test/quadratic_root_solver_checker.sv
// Checker for the quadratic root solver: predicts each result word and compares it
`timescale 1ns / 100ps

module quadratic_root_solver_checker (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [qrs_pkg::IN_W-1:0] s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [qrs_pkg::TD_W-1:0] m_tdata,
    output int                       fail_count,
    output int                       pending_count,
    output int                       result_count
);
    import qrs_pkg::*;

    localparam longint MAX_Q = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint MIN_Q = -MAX_Q - 1;

    // last member sits in the lowest bits, matching the word layout
    typedef struct packed {
        logic signed [OUT_W-1:0] r2i;
        logic signed [OUT_W-1:0] r2r;
        logic signed [OUT_W-1:0] r1i;
        logic signed [OUT_W-1:0] r1r;
        logic signed [DW-1:0]    disc;
        logic                    dbl;
        logic                    hasr;
        logic                    legal;
    } roots_t;

    roots_t expected_roots[$];

    // floor(sqrt(d) * 2^FRAC_BITS), bit by bit on 128-bit squares
    function automatic longint root_scaled(input longint d);
        logic [127:0] target;
        logic [127:0] sq;
        longint s;
        longint t;
        target = 128'(d) << (2 * FRAC_BITS);
        s = 0;
        for (int k = 17 + FRAC_BITS; k >= 0; k--) begin
            t = s | (64'sd1 <<< k);
            sq = 128'(t) * 128'(t);
            if (sq <= target) s = t;
        end
        return s;
    endfunction

    function automatic longint quot_sat(input longint num, input longint den);
        longint q;
        q = num / den;
        if (q > MAX_Q) q = MAX_Q;
        if (q < MIN_Q) q = MIN_Q;
        return q;
    endfunction

    function automatic roots_t solve_roots(input logic [IN_W-1:0] word);
        roots_t r;
        longint a, b, c, d, s, nb;
        a = longint'($signed(word[15:0]));
        b = longint'($signed(word[31:16]));
        c = longint'($signed(word[47:32]));
        d = b * b - 4 * a * c;
        r = '0;
        r.legal = (a != 0);
        r.hasr = r.legal && d >= 0;
        r.dbl = r.hasr && d == 0;
        r.disc = DW'(d);
        if (r.legal) begin
            s = root_scaled(d < 0 ? -d : d);
            nb = -b * (64'sd1 <<< FRAC_BITS);
            if (d >= 0) begin
                r.r1r = OUT_W'(quot_sat(nb + s, 2 * a));
                r.r2r = OUT_W'(quot_sat(nb - s, 2 * a));
            end else begin
                r.r1r = OUT_W'(quot_sat(nb, 2 * a));
                r.r2r = r.r1r;
                r.r1i = OUT_W'(quot_sat(s, 2 * a));
                r.r2i = OUT_W'(quot_sat(-quot_sat(s, 2 * a), 1));
            end
        end
        return r;
    endfunction

    assign pending_count = expected_roots.size();

    always @(posedge aclk) begin
        roots_t want;
        roots_t got;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (s_tvalid && s_tready) expected_roots.push_back(solve_roots(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[TD_R2I+OUT_W-1:0];
                result_count <= result_count + 1;
                if (expected_roots.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result word %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_roots.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display("mismatch legal/real/dbl exp %b%b%b got %b%b%b",
                                want.legal, want.hasr, want.dbl, got.legal, got.hasr, got.dbl);
                            $display("  disc exp %0d got %0d", want.disc, got.disc);
                            $display("  r1 exp %0d,%0d got %0d,%0d",
                                want.r1r, want.r1i, got.r1r, got.r1i);
                            $display("  r2 exp %0d,%0d got %0d,%0d",
                                want.r2r, want.r2i, got.r2r, got.r2i);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> test/tb_quadratic_root_solver_unit.sv
// Testbench top for the quadratic root solver: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_quadratic_root_solver_unit;
    import qrs_pkg::*;

    localparam int RANDOM_WORDS = 950;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [TD_W-1:0]  m_tdata;
    int               fail_count, pending_count, result_count;
    bit               calm = 1'b0;
    int               sent = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    quadratic_root_solver_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    quadratic_root_solver_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // offer one word; held until taken, random gaps inserted between words unless calm
    task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c);
        while (!calm && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(8)) - 4);
            3: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 16);

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [15:0] a, b, c;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // extremes, zero a, double root, complex and real roots
        send_coefs(16'h0000, 16'h0005, 16'h0003);
        send_coefs(16'h0000, 16'h0000, 16'h0000);
        send_coefs(16'h0001, 16'hfffe, 16'h0001);
        send_coefs(16'h0001, 16'h0000, 16'h0001);
        send_coefs(16'h0001, 16'h0000, 16'hffff);
        send_coefs(16'h0001, 16'hfffd, 16'h0002);
        send_coefs(16'h8000, 16'h8000, 16'h7fff);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
        send_coefs(16'h7fff, 16'h8000, 16'h8000);
        send_coefs(16'h0001, 16'h8000, 16'h8000);
        send_coefs(16'h0001, 16'h7fff, 16'h7fff);
        send_coefs(16'hffff, 16'h8000, 16'h7fff);
        send_coefs(16'hffff, 16'h0000, 16'h7fff);
        send_coefs(16'h8000, 16'h0000, 16'h0000);
        send_coefs(16'h0002, 16'h0004, 16'h0002);
        send_coefs(16'hffff, 16'hffff, 16'hffff);
        send_coefs(16'h0003, 16'h0001, 16'h7fff);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 300 && n < 450);
            a = pick_coef();
            b = pick_coef();
            if ($urandom_range(3) == 0) begin
                // near-double root: c = b*b / (4a)
                if (a == 0) a = 16'h0001;
                c = 16'((longint'($signed(b)) * $signed(b)) / (4 * longint'($signed(a))));
            end else begin
                c = pick_coef();
            end
            send_coefs(a, b, c);
        end
        s_tvalid <= 1'b0;
        calm = 1'b1;
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Covered %0d coefficient sets, %0d result words checked.", sent, result_count);
        $display("Zero a, double, real and complex roots and full-scale coefficients included.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/qrs_pkg.sv
rtl/core/qrs_sqrt_cell.sv
rtl/core/qrs_div_cell.sv
rtl/core/quadratic_root_solver_unit.sv
rtl/core/qrs_checker.sv
test/quadratic_root_solver_checker.sv
test/tb_quadratic_root_solver_unit.sv
